// ----- rtl/core/lrlr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrlr_pkg
// Shared types and constants for the log ring with whole-line reclaim.
// ----------------------------------------------------------------------------
package lrlr_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Fixed field widths of the item and result beats
  localparam int BYTE_W    = 8;
  localparam int RESERVE_W = 11;
  localparam int READMAX_W = 7;
  localparam int USED_W    = 11;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_WCHK = 7'b0000010,
    ST_WTST = 7'b0000100,
    ST_WPUT = 7'b0001000,
    ST_RRD  = 7'b0010000,
    ST_RCAP = 7'b0100000,
    ST_OUT  = 7'b1000000
  } lrlr_state_t;

endpackage

// ----- rtl/core/log_ring_line_reclaim_top.sv -----
`timescale 1ns / 1ps
// Write: an item goes to the check state; while room is short it reads the next
//   byte and tests it for a newline in the test state, and with no newline left
//   it discards the whole ring, before the store state writes the byte.
// Read: each returned byte is read and then captured from the single read port of
//   the byte store; no new item is taken until the final result beat is taken.
// Reset: synchronous, active low; empties the ring. The byte store is not
//   cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// log_ring_line_reclaim_top
// Byte ring for log text that evicts whole oldest lines to make room and
// returns runs of the oldest bytes on request.
// ----------------------------------------------------------------------------
module log_ring_line_reclaim_top import lrlr_pkg::*; #(
  parameter int RING_BYTES   = 1024,
  parameter int MAX_READ_RUN = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [BYTE_W-1:0]    in_write_byte,
  input  logic [RESERVE_W-1:0] in_reserve_bytes,
  input  logic [READMAX_W-1:0] in_read_max,
  input  logic                 in_consume,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_read_byte,
  output logic                 out_byte_valid,
  output logic                 out_last,
  output logic [USED_W-1:0]    out_used_bytes
);

  localparam int SPAN = 2 * RING_BYTES;
  localparam int PW   = $clog2(SPAN);
  localparam int AW   = $clog2(RING_BYTES);
  localparam int CW   = (PW > RESERVE_W) ? PW : RESERVE_W;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(SPAN - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot(input logic [PW-1:0] p);
    logic [PW-1:0] d;
    d = p - PW'(RING_BYTES);
    return (p >= PW'(RING_BYTES)) ? d[AW-1:0] : p[AW-1:0];
  endfunction

  lrlr_state_t state_r, state_nxt;
  logic [PW-1:0]        head_r, head_nxt;
  logic [PW-1:0]        tail_r, tail_nxt;
  logic [PW-1:0]        ptr_r, ptr_nxt;
  logic [PW-1:0]        need_r, need_nxt;
  logic [BYTE_W-1:0]    byte_r, byte_nxt;
  logic [READMAX_W-1:0] cnt_r, cnt_nxt;
  logic [USED_W-1:0]    used_r, used_nxt;
  logic                 consume_r, consume_nxt;
  logic [BYTE_W-1:0]    obyte_r, obyte_nxt;
  logic                 obv_r, obv_nxt;
  logic                 olast_r, olast_nxt;
  logic [USED_W-1:0]    oused_r, oused_nxt;

  logic [PW:0]          held_wide;
  logic [PW-1:0]        held;
  logic [PW-1:0]        free_cnt;
  logic [CW-1:0]        rsv_clip;
  logic [READMAX_W-1:0] rmax_clip;
  logic [READMAX_W-1:0] run_len;
  logic [PW-1:0]        used_after;

  logic                 ram_we;
  logic                 ram_re;
  logic [BYTE_W-1:0]    ram_rdata;

  lrlr_ram #(
    .DEPTH (RING_BYTES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot(head_r)),
    .wr_data (byte_r),
    .rd_en   (ram_re),
    .rd_addr (slot(ptr_r)),
    .rd_data (ram_rdata)
  );

  always_comb begin
    held_wide = {1'b0, head_r} + (PW + 1)'(SPAN) - {1'b0, tail_r};
    if (head_r >= tail_r) begin
      held = head_r - tail_r;
    end else begin
      held = held_wide[PW-1:0];
    end
    free_cnt = PW'(RING_BYTES) - held;

    // Clip the reservation to the ring size, and at least one byte
    rsv_clip = CW'(in_reserve_bytes);
    if (rsv_clip > CW'(RING_BYTES)) begin
      rsv_clip = CW'(RING_BYTES);
    end
    if (rsv_clip == '0) begin
      rsv_clip = CW'(1);
    end

    rmax_clip = in_read_max;
    if (rmax_clip > READMAX_W'(MAX_READ_RUN)) begin
      rmax_clip = READMAX_W'(MAX_READ_RUN);
    end
    if (CW'(rmax_clip) > CW'(held)) begin
      run_len = held[READMAX_W-1:0];
    end else begin
      run_len = rmax_clip;
    end
    used_after = in_consume ? held - PW'(run_len) : held;
  end

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    ptr_nxt     = ptr_r;
    need_nxt    = need_r;
    byte_nxt    = byte_r;
    cnt_nxt     = cnt_r;
    used_nxt    = used_r;
    consume_nxt = consume_r;
    obyte_nxt   = obyte_r;
    obv_nxt     = obv_r;
    olast_nxt   = olast_r;
    oused_nxt   = oused_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ptr_nxt = tail_r;
          if (in_operation == OP_WRITE) begin
            byte_nxt    = in_write_byte;
            need_nxt    = rsv_clip[PW-1:0];
            consume_nxt = 1'b0;
            state_nxt   = ST_WCHK;
          end else begin
            cnt_nxt     = run_len;
            used_nxt    = USED_W'(used_after);
            consume_nxt = in_consume;
            if (run_len == '0) begin
              obyte_nxt = '0;
              obv_nxt   = 1'b0;
              olast_nxt = 1'b1;
              oused_nxt = USED_W'(used_after);
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_RRD;
            end
          end
        end
      end
      ST_WCHK: begin
        if (free_cnt >= need_r) begin
          state_nxt = ST_WPUT;
        end else if (ptr_r == head_r) begin
          // no newline left: drop everything held
          tail_nxt = head_r;
        end else begin
          ram_re    = 1'b1;
          state_nxt = ST_WTST;
        end
      end
      ST_WTST: begin
        ptr_nxt = ptr_inc(ptr_r);
        if (ram_rdata == NEWLINE_CODE) begin
          tail_nxt = ptr_inc(ptr_r);
        end
        state_nxt = ST_WCHK;
      end
      ST_WPUT: begin
        ram_we    = 1'b1;
        head_nxt  = ptr_inc(head_r);
        obyte_nxt = '0;
        obv_nxt   = 1'b0;
        olast_nxt = 1'b1;
        oused_nxt = USED_W'(held + 1'b1);
        state_nxt = ST_OUT;
      end
      ST_RRD: begin
        ram_re    = 1'b1;
        ptr_nxt   = ptr_inc(ptr_r);
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = ST_RCAP;
      end
      ST_RCAP: begin
        obyte_nxt = ram_rdata;
        obv_nxt   = 1'b1;
        olast_nxt = (cnt_r == '0);
        oused_nxt = used_r;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          if (olast_r) begin
            if (consume_r) begin
              tail_nxt = ptr_r;
            end
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_RRD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    need_r    <= need_nxt;
    byte_r    <= byte_nxt;
    cnt_r     <= cnt_nxt;
    used_r    <= used_nxt;
    consume_r <= consume_nxt;
    obyte_r   <= obyte_nxt;
    obv_r     <= obv_nxt;
    olast_r   <= olast_nxt;
    oused_r   <= oused_nxt;
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_OUT);
  assign out_read_byte  = obyte_r;
  assign out_byte_valid = obv_r;
  assign out_last       = olast_r;
  assign out_used_bytes = oused_r;

endmodule

// ----- rtl/core/lrlr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrlr_ram
// Byte store of the ring: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lrlr_ram import lrlr_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/lrlr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrlr_checker
// Port-level checks for the log ring, bound to the top level.
// ----------------------------------------------------------------------------
module lrlr_checker import lrlr_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_operation,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [BYTE_W-1:0]    out_read_byte,
  input logic                 out_byte_valid,
  input logic                 out_last,
  input logic [USED_W-1:0]    out_used_bytes
);

  // A pending result beat blocks new items
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result beat is pending");

  a_empty_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last && (out_read_byte == '0))
    else $error("beat without a byte is not a zero final beat");

  // An accepted write item is not followed by a result beat right after it
  a_write_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_WRITE) |=> !out_valid)
    else $error("write result appeared too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_byte)
      && $stable(out_last) && $stable(out_used_bytes))
    else $error("stalled result beat changed");

endmodule

bind log_ring_line_reclaim_top lrlr_checker u_lrlr_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the log byte ring with whole-line reclaim. Drives
// byte writes (lines with reservations, oversized and zero reservations,
// stray bytes) and read runs of the oldest bytes, predicts every result beat
// with a local ring model, and checks beats in order under random idling on
// both handshakes.
// ----------------------------------------------------------------------------
module tb;
  import lrlr_pkg::*;

  localparam int RING_BYTES     = 1024;
  localparam int MAX_READ_RUN   = 64;
  localparam int PTR_SPAN       = 2 * RING_BYTES;
  localparam int RANDOM_ITEMS   = 125;
  localparam int MAX_GAP        = 14;
  localparam int DRAIN_CYCLES   = 64;
  // a write that scans the whole ring for a newline passes the check and test states once per byte
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic                 operation;
    logic [BYTE_W-1:0]    write_byte;
    logic [RESERVE_W-1:0] reserve_bytes;
    logic [READMAX_W-1:0] read_max;
    logic                 consume;
    int                   gap;
  } log_item_t;

  typedef struct {
    logic [BYTE_W-1:0] read_byte;
    logic              byte_valid;
    logic              last;
    logic [USED_W-1:0] used_bytes;
  } ring_beat_t;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic                 in_operation     = OP_WRITE;
  logic [BYTE_W-1:0]    in_write_byte    = '0;
  logic [RESERVE_W-1:0] in_reserve_bytes = '0;
  logic [READMAX_W-1:0] in_read_max      = '0;
  logic                 in_consume       = 1'b0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic [BYTE_W-1:0]    out_read_byte;
  logic                 out_byte_valid;
  logic                 out_last;
  logic [USED_W-1:0]    out_used_bytes;

  log_item_t  log_items[$];
  ring_beat_t predicted_beats[$];
  ring_beat_t exp_beat;
  log_item_t  cur_item;

  // ring model state
  logic [7:0] ring_mem [RING_BYTES];
  int head_ptr = 0;
  int tail_ptr = 0;

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  bit   tx_steady = 1'b0;
  bit   rx_steady = 1'b0;
  bit   gap_drawn = 1'b0;
  int   tx_wait   = 0;
  int   rx_wait   = 0;

  int error_count    = 0;
  int accepted_items = 0;
  int total_items    = 0;
  int checked_beats  = 0;
  int write_items    = 0;
  int read_items     = 0;
  int line_evictions = 0;
  int ring_wipes     = 0;
  int peak_fill      = 0;
  int idle_cycles    = 0;

  log_ring_line_reclaim_top #(
    .RING_BYTES   (RING_BYTES),
    .MAX_READ_RUN (MAX_READ_RUN)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_write_byte    (in_write_byte),
    .in_reserve_bytes (in_reserve_bytes),
    .in_read_max      (in_read_max),
    .in_consume       (in_consume),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_byte    (out_read_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last         (out_last),
    .out_used_bytes   (out_used_bytes)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Ring model
  // --------------------------------------------------------------------------
  function automatic int ring_fill();
    return (head_ptr - tail_ptr + PTR_SPAN) % PTR_SPAN;
  endfunction

  task automatic push_beat(input logic [7:0] b, input logic v, input logic l, input int used);
    ring_beat_t beat;
    beat.read_byte  = b;
    beat.byte_valid = v;
    beat.last       = l;
    beat.used_bytes = USED_W'(used);
    predicted_beats.push_back(beat);
  endtask

  // advance the tail just past the oldest newline, or empty the ring if none is held
  task automatic drop_oldest_line();
    int held;
    int k;
    int p;
    bit found;
    held  = ring_fill();
    found = 1'b0;
    for (k = 0; k < held && !found; k++) begin
      p = (tail_ptr + k) % PTR_SPAN;
      if (ring_mem[p % RING_BYTES] == NEWLINE_CODE) begin
        tail_ptr = (p + 1) % PTR_SPAN;
        found    = 1'b1;
      end
    end
    if (!found) begin
      tail_ptr = head_ptr;
      ring_wipes++;
    end
    line_evictions++;
  endtask

  task automatic log_ring_apply(input logic op, input logic [7:0] wb,
                                input logic [RESERVE_W-1:0] reserve,
                                input logic [READMAX_W-1:0] rmax, input logic take);
    int need;
    int held;
    int len;
    int used_after;
    int k;
    if (op == OP_WRITE) begin
      write_items++;
      need = int'(reserve);
      if (need > RING_BYTES) need = RING_BYTES;
      if (need == 0) need = 1;
      while (RING_BYTES - ring_fill() < need) drop_oldest_line();
      ring_mem[head_ptr % RING_BYTES] = wb;
      head_ptr = (head_ptr + 1) % PTR_SPAN;
      push_beat(8'h00, 1'b0, 1'b1, ring_fill());
    end else begin
      read_items++;
      held = ring_fill();
      len  = int'(rmax);
      if (len > MAX_READ_RUN) len = MAX_READ_RUN;
      if (len > held) len = held;
      used_after = take ? held - len : held;
      if (len == 0) begin
        push_beat(8'h00, 1'b0, 1'b1, used_after);
      end else begin
        for (k = 0; k < len; k++) begin
          push_beat(ring_mem[((tail_ptr + k) % PTR_SPAN) % RING_BYTES], 1'b1,
                    k == len - 1, used_after);
        end
      end
      if (take) tail_ptr = (tail_ptr + len) % PTR_SPAN;
    end
    if (ring_fill() > peak_fill) peak_fill = ring_fill();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_item(input logic op, input logic [7:0] wb, input int reserve,
                            input int rmax, input logic take);
    log_item_t it;
    it.operation     = op;
    it.write_byte    = wb;
    it.reserve_bytes = RESERVE_W'(reserve);
    it.read_max      = READMAX_W'(rmax);
    it.consume       = take;
    it.gap           = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    log_items.push_back(it);
    if ($urandom_range(0, 29) == 0) tx_steady = !tx_steady;
  endtask

  // unused fields carry random values; the block must ignore them
  task automatic queue_write(input logic [7:0] wb, input int reserve);
    queue_item(OP_WRITE, wb, reserve, $urandom_range(0, 127), 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_read(input int rmax, input logic take);
    queue_item(OP_READ, 8'($urandom_range(0, 255)), $urandom_range(0, 2047), rmax, take);
  endtask

  // first byte reserves the whole string
  task automatic queue_string(input int len, input int first_reserve, input bit ends_line);
    int k;
    logic [7:0] b;
    for (k = 0; k < len; k++) begin
      b = 8'($urandom_range(0, 255));
      if (k == len - 1 && ends_line) b = NEWLINE_CODE;
      queue_write(b, (k == 0) ? first_reserve : 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: input channel
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (log_items.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        if (!gap_drawn) begin
          tx_wait   = log_items[0].gap;
          gap_drawn = 1'b1;
        end
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else begin
          cur_item  = log_items.pop_front();
          gap_drawn = 1'b0;
          in_valid         <= 1'b1;
          in_operation     <= cur_item.operation;
          in_write_byte    <= cur_item.write_byte;
          in_reserve_bytes <= cur_item.reserve_bytes;
          in_read_max      <= cur_item.read_max;
          in_consume       <= cur_item.consume;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: result channel back-pressure, one stall drawn per beat
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (out_taken || !out_ready)) begin
      if (out_taken) begin
        rx_wait = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and checker
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [10:0] expv,
                             input logic [10:0] actv);
    if (actv !== expv) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        accepted_items++;
        log_ring_apply(in_operation, in_write_byte, in_reserve_bytes, in_read_max,
                       in_consume);
      end
      if (out_valid && out_ready) begin
        if (predicted_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got byte=%02h valid=%b last=%b used=%0d",
                   $time, out_read_byte, out_byte_valid, out_last, out_used_bytes);
          error_count++;
        end else begin
          exp_beat = predicted_beats.pop_front();
          checked_beats++;
          check_field("read_byte", exp_beat.read_byte, out_read_byte);
          check_field("byte_valid", exp_beat.byte_valid, out_byte_valid);
          check_field("last", exp_beat.last, out_last);
          check_field("used_bytes", exp_beat.used_bytes, out_used_bytes);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: stop when no beat moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, predicted_beats.size());
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int base;
    int len;
    int reserve;
    int pick;

    // directed: empty reads, zero and tiny reservations, extreme bytes
    queue_read(5, 1'b1);
    queue_read(0, 1'b0);
    queue_write(8'h41, 0);
    queue_write(8'hFF, 1);
    queue_write(8'h00, 0);
    queue_write(NEWLINE_CODE, 0);
    queue_write(8'h42, 3);
    queue_write(8'h43, 0);
    queue_write(NEWLINE_CODE, 0);
    // zero-length read on a held ring, then a long request cut to what is held
    queue_read(0, 1'b1);
    queue_read(127, 1'b0);
    queue_read(2, 1'b1);
    // full-ring reservation evicts both held lines
    queue_write(8'h44, RING_BYTES);
    // oversized reservation with no newline held: whole ring goes
    queue_write(8'h45, 2047);
    queue_write(8'h46, RING_BYTES - 1);
    queue_write(8'h47, RING_BYTES - 1);
    queue_read(MAX_READ_RUN, 1'b1);
    queue_string(6, 6, 1'b1);
    queue_read(1, 1'b0);

    // random: mostly whole lines, some reads, some stray writes
    base = log_items.size();
    while (log_items.size() - base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        len     = $urandom_range(1, 24);
        reserve = len;
        if ($urandom_range(0, 5) == 0) reserve = $urandom_range(RING_BYTES - 96, RING_BYTES);
        queue_string(len, reserve, $urandom_range(0, 4) != 0);
      end else if (pick < 17) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_read($urandom_range(0, 127), 1'($urandom_range(0, 1)));
        end else begin
          queue_read($urandom_range(1, 24), 1'($urandom_range(0, 1)));
        end
      end else begin
        queue_write(8'($urandom_range(0, 255)), $urandom_range(0, 2047));
      end
    end
    total_items = log_items.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_items < total_items || predicted_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("summary: %0d items (%0d writes, %0d reads), %0d result beats checked",
             total_items, write_items, read_items, checked_beats);
    $display("summary: %0d line evictions, %0d whole-ring discards, peak fill %0d bytes",
             line_evictions, ring_wipes, peak_fill);
    if (error_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
